FILE: rtl/mfp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package mfp_pkg;

  localparam int STORE_DEPTH = 32;
  localparam int CH_MAX      = 6;

  localparam logic [7:0] BUSY_BYTE  = 8'hB5;
  localparam logic [7:0] END_BYTE   = 8'hC0;
  localparam logic [7:0] ID_VOLTAGE = 8'h0D;
  localparam logic [7:0] ID_CURRENT = 8'h0E;
  localparam logic [7:0] ID_POWER   = 8'h0F;
  localparam logic [7:0] ID_ENERGY  = 8'h10;

  typedef enum logic [2:0] {
    KIND_VOLTAGE = 3'd0,
    KIND_CURRENT = 3'd1,
    KIND_POWER   = 3'd2,
    KIND_ENERGY  = 3'd3,
    KIND_BAD_END = 3'd4,
    KIND_BAD_SUM = 3'd5,
    KIND_BAD_ID  = 3'd6
  } kind_t;

  // One finished frame's worth of results, handed to the serialiser.
  typedef struct packed {
    kind_t                   kind;
    logic [2:0]              count;
    logic [CH_MAX-1:0][31:0] value;
  } batch_t;

endpackage

`default_nettype wire

FILE: rtl/mfp_byte_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

FILE: rtl/mfp_result_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface mfp_result_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [2:0]  channel;
  logic [31:0] value;
  logic        last;

  modport source (output valid, output kind, output channel, output value, output last,
                  input ready);
  modport sink   (input valid, input kind, input channel, input value, input last,
                  output ready);
endinterface

`default_nettype wire

FILE: rtl/mfp_frame_rx.sv
`timescale 1ns / 1ps
`default_nettype none

module mfp_frame_rx
  import mfp_pkg::*;
#(
  parameter int MAX_FRAME_LENGTH = 32,
  parameter int CHANNELS         = 6
) (
  input  wire        clk,
  input  wire        rst,
  mfp_byte_if.sink   rx,
  input  wire        batch_done,
  output logic       batch_valid,
  output batch_t     batch
);

  localparam int LEN_W = $clog2(MAX_FRAME_LENGTH);
  localparam int POS_W = $clog2(MAX_FRAME_LENGTH + 1);

  logic             collecting;
  logic [LEN_W-1:0] frame_length;
  logic [POS_W-1:0] byte_position;
  logic [7:0]       running_sum;
  logic [7:0]       store [STORE_DEPTH];
  logic [31:0]      totals [CH_MAX];

  logic             accept;
  logic [8:0]       pos_ext;
  logic [8:0]       len_ext;
  logic             in_store;
  logic             finish;
  logic             len_ok;
  logic [7:0]       view [STORE_DEPTH];
  logic [7:0]       sum_byte;
  logic [31:0]      totals_next [CH_MAX];
  batch_t           batch_next;

  assign rx.ready = !batch_valid || batch_done;
  assign accept   = rx.valid && rx.ready;
  assign pos_ext  = 9'(byte_position);
  assign len_ext  = 9'(frame_length);
  assign in_store = pos_ext < 9'(STORE_DEPTH);
  assign finish   = collecting && (pos_ext >= len_ext + 9'd1);
  assign len_ok   = (rx.rx_byte != 8'd0) && (rx.rx_byte != BUSY_BYTE) &&
                    ({1'b0, rx.rx_byte} < 9'(MAX_FRAME_LENGTH));

  // Store contents as seen after this byte is written (end byte included).
  always_comb begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      view[i] = (in_store && pos_ext[4:0] == 5'(i)) ? rx.rx_byte : store[i];
    end
    sum_byte = (len_ext < 9'(STORE_DEPTH)) ? view[len_ext[4:0]] : 8'd0;
  end

  always_comb begin
    batch_next       = '0;
    batch_next.count = 3'd1;
    for (int i = 0; i < CH_MAX; i++) begin
      totals_next[i] = totals[i];
    end
    if (rx.rx_byte != END_BYTE) begin
      batch_next.kind = KIND_BAD_END;
    end else if (sum_byte != running_sum) begin
      batch_next.kind = KIND_BAD_SUM;
    end else begin
      case (view[1])
        ID_VOLTAGE: begin
          batch_next.kind     = KIND_VOLTAGE;
          batch_next.value[0] = {16'd0, view[2], view[3]};
        end
        ID_CURRENT: begin
          batch_next.kind  = KIND_CURRENT;
          batch_next.count = 3'(CHANNELS);
          for (int i = 0; i < CH_MAX; i++) begin
            batch_next.value[i] = {16'd0, view[2+2*i], view[3+2*i]};
          end
        end
        ID_POWER: begin
          batch_next.kind  = KIND_POWER;
          batch_next.count = 3'(CHANNELS);
          for (int i = 0; i < CH_MAX; i++) begin
            batch_next.value[i] = {view[2+4*i], view[3+4*i], view[4+4*i], view[5+4*i]};
          end
        end
        ID_ENERGY: begin
          batch_next.kind  = KIND_ENERGY;
          batch_next.count = 3'(CHANNELS);
          for (int i = 0; i < CH_MAX; i++) begin
            if (i < CHANNELS) begin
              totals_next[i] = totals[i] +
                               {view[2+4*i], view[3+4*i], view[4+4*i], view[5+4*i]};
            end
            batch_next.value[i] = totals_next[i];
          end
        end
        default: begin
          batch_next.kind = KIND_BAD_ID;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      collecting    <= 1'b0;
      frame_length  <= '0;
      byte_position <= '0;
      running_sum   <= 8'd0;
      batch_valid   <= 1'b0;
      for (int i = 0; i < STORE_DEPTH; i++) begin
        store[i] <= 8'd0;
      end
      for (int i = 0; i < CH_MAX; i++) begin
        totals[i] <= 32'd0;
      end
    end else begin
      if (batch_done) begin
        batch_valid <= 1'b0;
      end
      if (accept) begin
        if (!collecting) begin
          if (len_ok) begin
            store[0]      <= rx.rx_byte;
            frame_length  <= LEN_W'(rx.rx_byte);
            byte_position <= POS_W'(1);
            running_sum   <= 8'd0;
            collecting    <= 1'b1;
          end
        end else begin
          if (in_store) begin
            store[pos_ext[4:0]] <= rx.rx_byte;
          end
          if (pos_ext < len_ext) begin
            running_sum <= running_sum + rx.rx_byte;
          end
          if (finish) begin
            collecting    <= 1'b0;
            byte_position <= '0;
            batch_valid   <= 1'b1;
            for (int i = 0; i < CH_MAX; i++) begin
              totals[i] <= totals_next[i];
            end
          end else begin
            byte_position <= byte_position + POS_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && finish) begin
      batch <= batch_next;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/mfp_burst_tx.sv
`timescale 1ns / 1ps
`default_nettype none

module mfp_burst_tx
  import mfp_pkg::*;
(
  input  wire          clk,
  input  wire          rst,
  input  wire          batch_valid,
  input  batch_t       batch,
  output logic         batch_done,
  mfp_result_if.source result
);

  logic [2:0] idx;
  logic       load;
  logic       is_last;

  assign load       = batch_valid && (!result.valid || result.ready);
  assign is_last    = (idx == batch.count - 3'd1);
  assign batch_done = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
      idx          <= 3'd0;
    end else begin
      if (load) begin
        result.valid <= 1'b1;
        idx          <= is_last ? 3'd0 : idx + 3'd1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result.kind    <= batch.kind;
      result.channel <= idx;
      result.value   <= batch.value[idx];
      result.last    <= is_last;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/meter_frame_parser.sv
`timescale 1ns / 1ps
`default_nettype none

// Meter frame parser.
// rx: one serial byte per transaction. result: one measurement or status per
// transaction, with last marking the final result caused by a given byte.
// Frames are length byte, id, big-endian payload, checksum, end byte 0xC0.
// The byte that closes a frame produces a batch of one result (voltage or
// status) or CHANNELS results (current, power, energy); the batch is held in
// the batch register, then moved result by result to the output register,
// one per cycle while result is ready. Throughput is one byte per cycle
// except while a batch drains: while the single batch register holds a
// batch, no byte is taken unless its last result moves to the output
// register in the same cycle.
// The output register lets a byte be taken while a result waits; a stall on
// result holds that register and, once a batch is pending, rx.ready drops.
// Reset clears parser state, the frame store, energy totals and all valids.
module meter_frame_parser
  import mfp_pkg::*;
#(
  parameter int MAX_FRAME_LENGTH = 32,
  parameter int CHANNELS         = 6
) (
  input  wire          clk,
  input  wire          rst,
  mfp_byte_if.sink     rx,
  mfp_result_if.source result
);

  // Hand-off between the frame receiver and the result serialiser.
  logic   batch_valid;
  logic   batch_done;
  batch_t batch;

  // Byte-level parsing, frame store, checksum and energy accumulation.
  mfp_frame_rx #(
    .MAX_FRAME_LENGTH (MAX_FRAME_LENGTH),
    .CHANNELS         (CHANNELS)
  ) u_frame_rx (
    .clk         (clk),
    .rst         (rst),
    .rx          (rx),
    .batch_done  (batch_done),
    .batch_valid (batch_valid),
    .batch       (batch)
  );

  // Drains one batch into the registered result channel, one result per cycle while result is ready.
  mfp_burst_tx u_burst_tx (
    .clk         (clk),
    .rst         (rst),
    .batch_valid (batch_valid),
    .batch       (batch),
    .batch_done  (batch_done),
    .result      (result)
  );

endmodule

`default_nettype wire
